>>> src/ipv4_adf_pkg.sv
// Shared types, constants and helper functions for the IPv4 allow/deny prefix filter.
package ipv4_adf_pkg;

  // Field widths of the request and result items.
  localparam int ADDR_W      = 32;
  localparam int LEN_W       = 6;
  localparam int REQ_W       = 2;
  localparam int STATUS_W    = 2;
  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 8;

  // Default table depth.
  localparam int RULE_DEPTH_DEF = 32;

  // Request kinds.
  localparam logic [REQ_W-1:0] REQ_ADD   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_CHECK = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_BAD_LEN = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd2;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } ctl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic start;
    logic issue;
    logic commit;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_needed;
    logic scan_last;
    logic out_free;
  } dp_stat_t;

  // Network mask for a prefix length; lengths of 32 and above give all ones.
  function automatic logic [ADDR_W-1:0] len_mask(input logic [LEN_W-1:0] len);
    len_mask = ~({ADDR_W{1'b1}} >> len);
  endfunction

endpackage

>>> src/ipv4_adf_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module ipv4_adf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/ipv4_adf_ctrl.sv
// Controller state machine that sequences decode, table scan and result commit.
module ipv4_adf_ctrl
  import ipv4_adf_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd
);

  ctl_state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.load   = 1'b1;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd.start = 1'b1;
        if (stat.scan_needed) begin
          state_next = ST_SCAN;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_SCAN: begin
        cmd.issue = 1'b1;
        if (stat.scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // A loaded request is decoded in the next cycle.
  a_load_decode: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == ST_DECODE)
    else $error("request load not followed by decode");

  // The drain cycle always follows the last table read.
  a_drain_after_issue: assert property (@(posedge clk) disable iff (rst)
    state == ST_DRAIN |-> $past(cmd.issue))
    else $error("drain without a preceding table read");

  // Results are committed only from the finish state.
  a_commit_finish: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> state == ST_FINISH)
    else $error("result committed outside the finish state");

endmodule

>>> src/ipv4_adf_dp.sv
// Datapath: request registers, rule tables, scan compare logic and result register.
module ipv4_adf_dp
  import ipv4_adf_pkg::*;
#(
  parameter int RULE_DEPTH = RULE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [IN_TDATA_W-1:0]  in_data,
  input  logic [REQ_W-1:0]       in_req,
  input  ctl_cmd_t               cmd,
  output dp_stat_t               stat,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [OUT_TDATA_W-1:0] out_data
);

  localparam int IDXW = (RULE_DEPTH > 1) ? $clog2(RULE_DEPTH) : 1;
  localparam int CNTW = $clog2(RULE_DEPTH + 1);
  localparam int ENTW = ADDR_W + LEN_W;
  localparam logic [CNTW-1:0] MaxCount = CNTW'(RULE_DEPTH);
  localparam logic [LEN_W-1:0] MaxLen  = LEN_W'(ADDR_W);

  // Request registers.
  logic [REQ_W-1:0]  req_r;
  logic [LEN_W-1:0]  len_r;
  logic              sel_r;
  logic [ADDR_W-1:0] masked_r;
  logic [ADDR_W-1:0] src_r;
  logic [ADDR_W-1:0] dst_r;

  // Table fill counts and scan state.
  logic [CNTW-1:0] allow_count;
  logic [CNTW-1:0] deny_count;
  logic [CNTW-1:0] idx;
  logic [CNTW-1:0] rd_idx;
  logic            rd_valid;
  logic            allow_hit;
  logic            deny_hit;

  // Result register.
  logic                pass_r;
  logic [STATUS_W-1:0] status_r;

  // Table read data and compare terms.
  logic [ENTW-1:0]   allow_rd, deny_rd;
  logic [ADDR_W-1:0] a_pre, d_pre, a_mask, d_mask;
  logic [LEN_W-1:0]  a_len, d_len;
  logic              a_live, d_live, a_match, d_match;

  // Commit decisions.
  logic                len_ok, dup, sel_full, clear_all;
  logic                allow_we, deny_we;
  logic                pass_next;
  logic [STATUS_W-1:0] status_next;
  logic [CNTW-1:0]     scan_limit, sel_count;
  logic [ENTW-1:0]     wr_entry;

  // Rule tables, one entry of {length, masked prefix} per rule.
  ipv4_adf_ram #(.WIDTH(ENTW), .DEPTH(RULE_DEPTH), .AW(IDXW)) u_allow_ram (
    .clk   (clk),
    .we    (allow_we),
    .waddr (allow_count[IDXW-1:0]),
    .wdata (wr_entry),
    .raddr (idx[IDXW-1:0]),
    .rdata (allow_rd)
  );

  ipv4_adf_ram #(.WIDTH(ENTW), .DEPTH(RULE_DEPTH), .AW(IDXW)) u_deny_ram (
    .clk   (clk),
    .we    (deny_we),
    .waddr (deny_count[IDXW-1:0]),
    .wdata (wr_entry),
    .raddr (idx[IDXW-1:0]),
    .rdata (deny_rd)
  );

  assign wr_entry = {len_r, masked_r};

  // Scan length: the chosen table for an add, the longer table for a check.
  assign sel_count = sel_r ? deny_count : allow_count;
  always_comb begin
    if (req_r == REQ_CHECK) begin
      scan_limit = (allow_count > deny_count) ? allow_count : deny_count;
    end else begin
      scan_limit = sel_count;
    end
  end

  assign len_ok           = (len_r != '0) && (len_r <= MaxLen);
  assign stat.scan_needed = (scan_limit != '0) &&
                            ((req_r == REQ_CHECK) || ((req_r == REQ_ADD) && len_ok));
  assign stat.scan_last   = ((idx + 1'b1) == scan_limit);
  assign stat.out_free    = !out_valid || out_ready;

  // Compare the entries read in the previous cycle.
  assign a_pre  = allow_rd[ADDR_W-1:0];
  assign a_len  = allow_rd[ENTW-1:ADDR_W];
  assign d_pre  = deny_rd[ADDR_W-1:0];
  assign d_len  = deny_rd[ENTW-1:ADDR_W];
  assign a_mask = len_mask(a_len);
  assign d_mask = len_mask(d_len);
  assign a_live = rd_valid && (rd_idx < allow_count);
  assign d_live = rd_valid && (rd_idx < deny_count);

  always_comb begin
    if (req_r == REQ_ADD) begin
      a_match = (a_pre == masked_r) && (a_len == len_r);
      d_match = (d_pre == masked_r) && (d_len == len_r);
    end else begin
      a_match = ((src_r & a_mask) == a_pre) || ((dst_r & a_mask) == a_pre);
      d_match = ((src_r & d_mask) == d_pre) || ((dst_r & d_mask) == d_pre);
    end
  end

  // Result and table updates for the finished request.
  assign dup      = sel_r ? deny_hit : allow_hit;
  assign sel_full = (sel_count >= MaxCount);

  always_comb begin
    pass_next   = 1'b0;
    status_next = STAT_OK;
    clear_all   = 1'b0;
    allow_we    = 1'b0;
    deny_we     = 1'b0;
    case (req_r)
      REQ_ADD: begin
        if (!len_ok) begin
          status_next = STAT_BAD_LEN;
          clear_all   = 1'b1;
        end else if (!dup) begin
          if (sel_full) begin
            status_next = STAT_FULL;
            clear_all   = 1'b1;
          end else begin
            allow_we = cmd.commit && !sel_r;
            deny_we  = cmd.commit && sel_r;
          end
        end
      end
      REQ_CHECK: begin
        pass_next = !deny_hit && ((allow_count == '0) || allow_hit);
      end
      REQ_CLEAR: begin
        clear_all = 1'b1;
      end
      default: begin
        pass_next = 1'b0;
      end
    endcase
  end

  // Request capture; payload registers need no reset.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r    <= in_req;
      masked_r <= in_data[31:0] & len_mask(in_data[37:32]);
      len_r    <= in_data[37:32];
      sel_r    <= in_data[38];
      src_r    <= in_data[70:39];
      dst_r    <= in_data[102:71];
    end
    if (cmd.commit) begin
      pass_r   <= pass_next;
      status_r <= status_next;
    end
    rd_idx <= idx;
  end

  // Scan index, hit flags and table counts.
  always_ff @(posedge clk) begin
    if (rst) begin
      allow_count <= '0;
      deny_count  <= '0;
      idx         <= '0;
      rd_valid    <= 1'b0;
      allow_hit   <= 1'b0;
      deny_hit    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      rd_valid <= cmd.issue;
      if (cmd.start) begin
        idx       <= '0;
        allow_hit <= 1'b0;
        deny_hit  <= 1'b0;
      end else begin
        if (cmd.issue) begin
          idx <= idx + 1'b1;
        end
        if (a_live && a_match) begin
          allow_hit <= 1'b1;
        end
        if (d_live && d_match) begin
          deny_hit <= 1'b1;
        end
      end
      if (cmd.commit && clear_all) begin
        allow_count <= '0;
        deny_count  <= '0;
      end else begin
        if (allow_we) begin
          allow_count <= allow_count + 1'b1;
        end
        if (deny_we) begin
          deny_count <= deny_count + 1'b1;
        end
      end
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign out_data = {{(OUT_TDATA_W - 1 - STATUS_W){1'b0}}, status_r, pass_r};

  // Table counts never pass the table depth.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (allow_count <= MaxCount) && (deny_count <= MaxCount))
    else $error("rule count beyond table depth");

  // A result is committed only when the output register can take it.
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> stat.out_free)
    else $error("result committed over a pending result");

  // A new result appears only after a commit.
  a_valid_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.commit))
    else $error("result valid without a commit");

endmodule

>>> src/ipv4_allow_deny_prefix_filter_unit.sv
// Top level of the IPv4 allow/deny prefix filter: controller and datapath.
//
// Requests arrive on the s_axis channel: tuser carries the request kind (add a rule,
// check a packet, clear both tables) and tdata carries the rule and packet fields.
// Each request gives exactly one result on the m_axis channel: a pass bit and a
// status code (ok, invalid prefix length, table full).
// Requests are handled one at a time. After acceptance the request is decoded, then
// the rule tables are read one entry per cycle through the single read port of each
// table RAM, the last read is compared in the drain state, and the result is
// committed to the output register in the finish state once that register is free.
// The scan covers the chosen table's count for an add, the larger for a check; a
// clear, an invalid add, an unknown kind or a request with no entries skips it.
// Reset empties both tables by clearing their fill counts; no clearing pass is run.
// When the receiver stalls, the result waits in the output register and the next
// request is still accepted and processed; it waits for the output register before
// its own result is committed.
module ipv4_allow_deny_prefix_filter_unit
  import ipv4_adf_pkg::*;
#(
  parameter int RULE_DEPTH = RULE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // tdata: prefix_addr[31:0], prefix_len[37:32], list_select[38], src_addr[70:39],
  //        dst_addr[102:71], zero fill[103]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // tuser: req_type[1:0]
  input  logic [REQ_W-1:0]       s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // tdata: pass[0], status[2:1], zero fill[7:3]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  // Sequencer for decode, scan and commit.
  ipv4_adf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Tables, compare logic and result register.
  ipv4_adf_dp #(.RULE_DEPTH(RULE_DEPTH)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (s_axis_tdata),
    .in_req    (s_axis_tuser),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule

>>> test/ipv4_allow_deny_prefix_filter_unit_test.sv
// Self-checking testbench for the IPv4 allow/deny prefix filter with a tracking scoreboard.
module ipv4_allow_deny_prefix_filter_unit_test
  import ipv4_adf_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;
  localparam int LIST_ALLOW = 0;
  localparam int LIST_DENY = 1;
  localparam int RANDOM_ITEMS = 1850;
  localparam int LONG_HOLD = 400;

  // One filter request as it travels on the input channel.
  typedef struct packed {
    logic [REQ_W-1:0]  kind;
    logic [ADDR_W-1:0] prefix_addr;
    logic [LEN_W-1:0]  prefix_len;
    logic              list_sel;
    logic [ADDR_W-1:0] src;
    logic [ADDR_W-1:0] dst;
  } filter_req_t;

  // One filter result.
  typedef struct packed {
    logic                pass;
    logic [STATUS_W-1:0] status;
  } verdict_t;

  // Tracks both prefix tables and the verdicts still owed by the block.
  class prefix_acl_tracker;
    bit [ADDR_W-1:0] pfx [2][RULE_DEPTH_DEF];
    bit [LEN_W-1:0]  plen [2][RULE_DEPTH_DEF];
    int              cnt [2];
    verdict_t        verdicts [$];
    int              failures;
    int              results_seen;

    function new();
      wipe();
      failures = 0;
      results_seen = 0;
    endfunction

    static function bit [ADDR_W-1:0] mask_of(bit [LEN_W-1:0] len);
      return 32'hFFFF_FFFF << (32 - int'(len));
    endfunction

    function void wipe();
      cnt[LIST_ALLOW] = 0;
      cnt[LIST_DENY] = 0;
    endfunction

    function bit covers(int l, bit [ADDR_W-1:0] a);
      for (int i = 0; i < cnt[l]; i++) begin
        if ((a & mask_of(plen[l][i])) == pfx[l][i]) return 1'b1;
      end
      return 1'b0;
    endfunction

    // Applies one request to the tables and gives its verdict.
    function verdict_t apply(filter_req_t r);
      verdict_t v;
      int l;
      bit [ADDR_W-1:0] m;
      bit dup;
      v.pass = 1'b0;
      v.status = STAT_OK;
      case (r.kind)
        REQ_ADD: begin
          if (r.prefix_len < 1 || r.prefix_len > 32) begin
            wipe();
            v.status = STAT_BAD_LEN;
          end else begin
            l = int'(r.list_sel);
            m = r.prefix_addr & mask_of(r.prefix_len);
            dup = 1'b0;
            for (int i = 0; i < cnt[l]; i++) begin
              if (pfx[l][i] == m && plen[l][i] == r.prefix_len) dup = 1'b1;
            end
            // A duplicate is accepted silently, even into a full table.
            if (!dup) begin
              if (cnt[l] >= RULE_DEPTH_DEF) begin
                wipe();
                v.status = STAT_FULL;
              end else begin
                pfx[l][cnt[l]] = m;
                plen[l][cnt[l]] = r.prefix_len;
                cnt[l]++;
              end
            end
          end
        end
        REQ_CHECK: begin
          v.pass = !(covers(LIST_DENY, r.src) || covers(LIST_DENY, r.dst)) &&
                   (cnt[LIST_ALLOW] == 0 || covers(LIST_ALLOW, r.src) ||
                    covers(LIST_ALLOW, r.dst));
        end
        REQ_CLEAR: wipe();
        default: ;
      endcase
      return v;
    endfunction

    function void note_request(filter_req_t r);
      verdicts.push_back(apply(r));
    endfunction

    function void check_verdict(logic [OUT_TDATA_W-1:0] tdata);
      verdict_t want;
      results_seen++;
      if (verdicts.size() == 0) begin
        $error("result with no request waiting: tdata=%h", tdata);
        failures++;
        return;
      end
      want = verdicts.pop_front();
      if (tdata[0] !== want.pass) begin
        $error("pass: expected %0d, actual %0b", want.pass, tdata[0]);
        failures++;
      end
      if (tdata[2:1] !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, tdata[2:1]);
        failures++;
      end
      if (tdata[7:3] !== 5'd0) begin
        $error("zero fill: expected 0, actual %b", tdata[7:3]);
        failures++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata;
  logic [REQ_W-1:0] s_axis_tuser;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  prefix_acl_tracker acl;
  prefix_acl_tracker plan;
  bit calm = 1'b0;
  bit held_off = 1'b0;
  int counted = 0;

  ipv4_allow_deny_prefix_filter_unit uut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Observe both channels at the rising edge.
  always @(posedge clk) begin
    filter_req_t seen;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      seen.kind = s_axis_tuser;
      seen.prefix_addr = s_axis_tdata[31:0];
      seen.prefix_len = s_axis_tdata[37:32];
      seen.list_sel = s_axis_tdata[38];
      seen.src = s_axis_tdata[70:39];
      seen.dst = s_axis_tdata[102:71];
      acl.note_request(seen);
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      acl.check_verdict(m_axis_tdata);
    end
  end

  // Mostly short gaps, a few long ones, none during calm stretches.
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // A request of the given kind with every field random.
  function automatic filter_req_t any_req(logic [REQ_W-1:0] kind);
    filter_req_t r;
    r.kind = kind;
    r.prefix_addr = $urandom;
    r.prefix_len = LEN_W'($urandom_range(0, 63));
    r.list_sel = 1'($urandom_range(0, 1));
    r.src = $urandom;
    r.dst = $urandom;
    return r;
  endfunction

  function automatic filter_req_t mk_add(int l, logic [ADDR_W-1:0] a, logic [LEN_W-1:0] len);
    filter_req_t r;
    r = any_req(REQ_ADD);
    r.list_sel = 1'(l);
    r.prefix_addr = a;
    r.prefix_len = len;
    return r;
  endfunction

  function automatic filter_req_t mk_check(logic [ADDR_W-1:0] s, logic [ADDR_W-1:0] d);
    filter_req_t r;
    r = any_req(REQ_CHECK);
    r.src = s;
    r.dst = d;
    return r;
  endfunction

  // Re-adds a stored rule of table l with fresh host bits.
  function automatic filter_req_t echo_rule(int l);
    int i;
    i = $urandom_range(0, plan.cnt[l] - 1);
    return mk_add(l, plan.pfx[l][i] |
                  ($urandom & ~prefix_acl_tracker::mask_of(plan.plen[l][i])),
                  plan.plen[l][i]);
  endfunction

  // An address inside some stored rule, or a random one when both tables are empty.
  function automatic logic [ADDR_W-1:0] near_rule();
    int l;
    int i;
    if (plan.cnt[LIST_ALLOW] + plan.cnt[LIST_DENY] == 0) return $urandom;
    if (plan.cnt[LIST_ALLOW] == 0) l = LIST_DENY;
    else if (plan.cnt[LIST_DENY] == 0) l = LIST_ALLOW;
    else l = $urandom_range(0, 1);
    i = $urandom_range(0, plan.cnt[l] - 1);
    return plan.pfx[l][i] | ($urandom & ~prefix_acl_tracker::mask_of(plan.plen[l][i]));
  endfunction

  function automatic logic [ADDR_W-1:0] probe_addr();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return near_rule();
    if (r < 65) return 32'h0000_0000;
    if (r < 70) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  function automatic logic [LEN_W-1:0] rule_len();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 6'd1;
    if (r == 1) return 6'd32;
    if (r < 5) return LEN_W'($urandom_range(1, 8));
    return LEN_W'($urandom_range(9, 31));
  endfunction

  // Offers one request after a gap and waits for its acceptance.
  task automatic issue(filter_req_t r);
    int g;
    void'(plan.apply(r));
    counted++;
    g = idle_gap();
    repeat (g) begin
      @(negedge clk);
      s_axis_tvalid = 1'b0;
      s_axis_tdata = {8'h00, $urandom, $urandom, $urandom};
    end
    @(negedge clk);
    s_axis_tvalid = 1'b1;
    s_axis_tuser = r.kind;
    s_axis_tdata = {1'b0, r.dst, r.src, r.list_sel, r.prefix_len, r.prefix_addr};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Receiver: random stalls plus one long hold-off once traffic is flowing.
  initial begin
    int g;
    m_axis_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      g = idle_gap();
      if (g > 0) begin
        m_axis_tready = 1'b0;
        repeat (g) @(negedge clk);
      end
      m_axis_tready = 1'b1;
      @(negedge clk);
      if (!held_off && acl.results_seen >= 200) begin
        held_off = 1'b1;
        m_axis_tready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    int r;
    int n;
    int l;
    int guard;
    bit paused;
    acl = new();
    plan = new();
    paused = 1'b0;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = REQ_ADD;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part: empty tables, extremes, duplicates, bad lengths, unknown kind.
    issue(mk_check(32'h0000_0000, 32'hFFFF_FFFF));
    issue(mk_add(LIST_ALLOW, 32'hFFFF_FFFF, 6'd32));
    issue(mk_add(LIST_ALLOW, 32'h0000_0000, 6'd1));
    issue(mk_add(LIST_ALLOW, 32'h7FFF_FFFF, 6'd1));
    issue(mk_check(32'h1234_5678, 32'h8000_0000));
    issue(mk_check(32'h8000_0001, 32'h9000_0000));
    issue(mk_add(LIST_DENY, 32'h0A00_0001, 6'd32));
    issue(mk_check(32'h0A00_0001, 32'hFFFF_FFFF));
    issue(mk_check(32'h8000_0000, 32'h0A00_0001));
    issue(mk_add(LIST_ALLOW, 32'hFFFF_FFFF, 6'd0));
    issue(mk_check(32'h0A00_0001, 32'h0000_0000));
    issue(mk_add(LIST_DENY, 32'h0000_0000, 6'd32));
    issue(mk_add(LIST_ALLOW, 32'h0000_0000, 6'd33));
    issue(mk_add(LIST_DENY, 32'hFFFF_FFFF, 6'd63));
    issue('{kind: REQ_UNKNOWN, prefix_addr: '1, prefix_len: '1, list_sel: 1'b1,
            src: '1, dst: '1});
    issue(mk_add(LIST_DENY, 32'hC0A8_0000, 6'd16));
    issue(mk_add(LIST_DENY, 32'hC0A8_FFFF, 6'd16));
    issue(mk_check(32'hC0A8_1234, 32'h0000_0000));
    issue('{kind: REQ_CLEAR, prefix_addr: '1, prefix_len: '1, list_sel: 1'b1,
            src: '1, dst: '1});
    issue(mk_check(32'hFFFF_FFFF, 32'hFFFF_FFFF));

    // Random part built from short sequences.
    while (counted < RANDOM_ITEMS) begin
      calm = ($urandom_range(0, 9) == 0);
      if (!paused && counted >= RANDOM_ITEMS / 2) begin
        // Withdraw the last request and wait until every result is back.
        paused = 1'b1;
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (acl.verdicts.size() != 0) @(posedge clk);
      end
      r = $urandom_range(0, 99);
      if (r < 30) begin
        // Grow the tables, sometimes repeating a stored rule.
        n = $urandom_range(1, 12);
        repeat (n) begin
          l = $urandom_range(0, 1);
          if (plan.cnt[l] > 0 && $urandom_range(0, 3) == 0) issue(echo_rule(l));
          else issue(mk_add(l, $urandom, rule_len()));
        end
      end else if (r < 64) begin
        // Check packets, mostly with addresses inside stored rules.
        n = $urandom_range(1, 10);
        repeat (n) issue(mk_check(probe_addr(), probe_addr()));
      end else if (r < 70) begin
        // Fill one table, repeat a rule while full, then overflow it.
        l = $urandom_range(0, 1);
        if ($urandom_range(0, 1)) issue(any_req(REQ_CLEAR));
        guard = 0;
        while (plan.cnt[l] < RULE_DEPTH_DEF && guard < 80) begin
          issue(mk_add(l, $urandom, LEN_W'($urandom_range(12, 32))));
          guard++;
          if ($urandom_range(0, 5) == 0) issue(mk_check(near_rule(), $urandom));
        end
        if (plan.cnt[l] > 0) issue(echo_rule(l));
        issue(mk_check(probe_addr(), probe_addr()));
        issue(mk_add(l, $urandom, 6'd32));
      end else if (r < 80) begin
        // Noise: any kind with every field random.
        issue(any_req(REQ_W'($urandom_range(0, 3))));
      end else if (r < 90) begin
        // Bad length or a clear.
        if ($urandom_range(0, 1)) begin
          issue(mk_add(int'($urandom_range(0, 1)), $urandom,
                       ($urandom_range(0, 2) == 0) ? 6'd0 :
                       LEN_W'($urandom_range(33, 63))));
        end else begin
          issue(any_req(REQ_CLEAR));
        end
      end else begin
        issue(any_req(REQ_UNKNOWN));
      end
    end
    @(negedge clk);
    s_axis_tvalid = 1'b0;

    // Drain, then give the block time to show any stray result.
    while (acl.verdicts.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (acl.failures == 0 && acl.verdicts.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #30ms;
    $display("Verification failed");
    $finish;
  end

endmodule

>>> ipv4_allow_deny_prefix_filter_unit.f
src/ipv4_adf_pkg.sv
src/ipv4_adf_ram.sv
src/ipv4_adf_ctrl.sv
src/ipv4_adf_dp.sv
src/ipv4_allow_deny_prefix_filter_unit.sv
test/ipv4_allow_deny_prefix_filter_unit_test.sv
